// ===== hdl/rbs_pkg.sv =====
// Shared types and constants for the record bubble sort block.
package rbs_pkg;

  // Default storage depth in records
  localparam int unsigned MaxRecords = 32;

  localparam int unsigned KeyW = 16;
  localparam int unsigned TagW = 16;

  // Incoming record
  typedef struct packed {
    logic [KeyW-1:0] key_count;
    logic [TagW-1:0] tag_id;
    logic            last_item;
  } in_item_t;

  // Sorted record leaving the block
  typedef struct packed {
    logic [KeyW-1:0] out_key;
    logic [TagW-1:0] out_tag;
    logic            out_last;
    logic            overflowed;
  } out_item_t;

  // One stored record
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } rec_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_SORT_RD  = 6'b000010,
    ST_SORT_CMP = 6'b000100,
    ST_SORT_END = 6'b001000,
    ST_EMIT_RD  = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_e;

endpackage

// ===== hdl/record_bubble_sort_by_key.sv =====
// Record store with a bubble sort by key, largest first, and sorted read-out.
//
//   channel   | ports                          | handshake
//   ----------+--------------------------------+-------------------------------
//   records   | start, busy, in_item_i         | taken when start && !busy
//   results   | out_valid_o, out_item_o        | one-cycle strobe per item, no stall
//
// A record that is not last is stored (or dropped and flagged when full) and busy stays low.
// A last record starts the sort: each compare/swap step is a read state and then
// a compare state on the record memory, and the passes run for lim = n-1 down
// to 1, each closed by an end-of-pass write; each sorted item is then read and
// emitted in turn. Reset clears the sequencer, fill count and drop flag; the
// memory is not cleared. The receiver cannot stall.
module record_bubble_sort_by_key #(
  parameter int unsigned MAX_RECORDS = rbs_pkg::MaxRecords
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rbs_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  output rbs_pkg::out_item_t out_item_o
);

  localparam int unsigned AddrW = $clog2(MAX_RECORDS);
  localparam int unsigned CntW  = $clog2(MAX_RECORDS + 1);
  localparam logic [CntW-1:0]  Cap     = CntW'(MAX_RECORDS);
  localparam logic [AddrW-1:0] LastIdx = AddrW'(MAX_RECORDS - 1);

  rbs_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  fill_q, fill_d;
  logic             drop_q, drop_d;
  logic [AddrW-1:0] ridx_q, ridx_d;
  logic [AddrW-1:0] lim_q, lim_d;
  rbs_pkg::rec_t    carry_q, carry_d;

  rbs_pkg::rec_t    rec_mem_q [MAX_RECORDS];
  rbs_pkg::rec_t    rd_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  rbs_pkg::rec_t    mem_wdata;

  logic             accept;
  logic             has_room;
  logic             swap;
  logic [CntW-1:0]  fill_m1;
  logic             emit_last;

  assign accept    = start && !busy;
  assign has_room  = fill_q < Cap;
  assign swap      = carry_q.key < rd_q.key;
  assign fill_m1   = fill_q - CntW'(1);
  assign emit_last = ridx_q == fill_m1[AddrW-1:0];

  // Record memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rec_mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= rec_mem_q[ridx_q];
  end

  // Select the write: load, compare step or end of pass
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ridx_q;
    mem_wdata = carry_q;
    case (state_q)
      rbs_pkg::ST_IDLE: begin
        mem_we        = accept && has_room;
        mem_waddr     = fill_q[AddrW-1:0];
        mem_wdata.key = in_item_i.key_count;
        mem_wdata.tag = in_item_i.tag_id;
      end
      rbs_pkg::ST_SORT_CMP: begin
        mem_we    = ridx_q != '0;
        mem_waddr = ridx_q - AddrW'(1);
        mem_wdata = swap ? rd_q : carry_q;
      end
      rbs_pkg::ST_SORT_END: begin
        mem_we    = 1'b1;
        mem_waddr = lim_q;
        mem_wdata = carry_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer: load, bubble passes, emit
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    drop_d  = drop_q;
    ridx_d  = ridx_q;
    lim_d   = lim_q;
    carry_d = carry_q;
    case (state_q)
      rbs_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_room) begin
            fill_d = fill_q + CntW'(1);
            lim_d  = fill_q[AddrW-1:0];
          end else begin
            drop_d = 1'b1;
            lim_d  = LastIdx;
          end
          if (in_item_i.last_item) begin
            ridx_d  = '0;
            state_d = (lim_d == '0) ? rbs_pkg::ST_EMIT_RD : rbs_pkg::ST_SORT_RD;
          end
        end
      end
      rbs_pkg::ST_SORT_RD: begin
        state_d = rbs_pkg::ST_SORT_CMP;
      end
      rbs_pkg::ST_SORT_CMP: begin
        // keep the smaller record bubbling toward the end
        if (ridx_q == '0 || !swap) begin
          carry_d = rd_q;
        end
        if (ridx_q == lim_q) begin
          state_d = rbs_pkg::ST_SORT_END;
        end else begin
          ridx_d  = ridx_q + AddrW'(1);
          state_d = rbs_pkg::ST_SORT_RD;
        end
      end
      rbs_pkg::ST_SORT_END: begin
        lim_d   = lim_q - AddrW'(1);
        ridx_d  = '0;
        state_d = (lim_q == AddrW'(1)) ? rbs_pkg::ST_EMIT_RD : rbs_pkg::ST_SORT_RD;
      end
      rbs_pkg::ST_EMIT_RD: begin
        state_d = rbs_pkg::ST_EMIT;
      end
      rbs_pkg::ST_EMIT: begin
        if (emit_last) begin
          fill_d  = '0;
          drop_d  = 1'b0;
          state_d = rbs_pkg::ST_IDLE;
        end else begin
          ridx_d  = ridx_q + AddrW'(1);
          state_d = rbs_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_d = rbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbs_pkg::ST_IDLE;
      fill_q  <= '0;
      drop_q  <= 1'b0;
      ridx_q  <= '0;
      lim_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      drop_q  <= drop_d;
      ridx_q  <= ridx_d;
      lim_q   <= lim_d;
    end
  end

  // Carried record, payload only
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  // Drive the result ports
  assign busy                  = state_q != rbs_pkg::ST_IDLE;
  assign out_valid_o           = state_q == rbs_pkg::ST_EMIT;
  assign out_item_o.out_key    = rd_q.key;
  assign out_item_o.out_tag    = rd_q.tag;
  assign out_item_o.out_last   = emit_last;
  assign out_item_o.overflowed = drop_q;

`ifndef SYNTHESIS
  // results only appear while the block is busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> busy)
    else $error("result strobe while idle");

  // a record that closes a batch starts the sort
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.last_item) |=> busy)
    else $error("last record did not start the sort");

  // a record that does not close the batch leaves the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !in_item_i.last_item) |=> !busy)
    else $error("block went busy on a non-last record");

  // the final result returns the block to idle with an empty store
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_last) |=> (!busy && fill_q == '0 && !drop_q))
    else $error("batch not closed after final result");

  // the fill count never passes the capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= Cap)
    else $error("fill count beyond capacity");
`endif

endmodule

// ===== sim/tb_record_bubble_sort_by_key.sv =====
// Self-checking testbench for the record bubble sort block.
`timescale 1ns / 1ps

module tb_record_bubble_sort_by_key;

  localparam int unsigned Depth = rbs_pkg::MaxRecords;
  localparam int unsigned IdlePct = 38;
  localparam int unsigned RandItems = 225;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  rbs_pkg::in_item_t  rec_in = '0;
  logic               out_valid_o;
  rbs_pkg::out_item_t out_item_o;

  // Records waiting to be sent and sorted records still to come out
  rbs_pkg::in_item_t  feed_q[$];
  rbs_pkg::out_item_t sorted_q[$];

  // Predictor copy of the record store
  logic [15:0] held_key [Depth];
  logic [15:0] held_tag [Depth];
  int unsigned held_cnt = 0;
  bit          dropped = 1'b0;

  logic        took_item = 1'b0;
  int unsigned fed_cnt = 0;
  int unsigned err_cnt = 0;

  record_bubble_sort_by_key #(
    .MAX_RECORDS(Depth)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_item_i  (rec_in),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Store one accepted record; on the batch end queue the sorted batch
  function automatic void absorb_record(rbs_pkg::in_item_t rec);
    logic [15:0] k;
    logic [15:0] t;
    rbs_pkg::out_item_t res;
    if (held_cnt < Depth) begin
      held_key[held_cnt] = rec.key_count;
      held_tag[held_cnt] = rec.tag_id;
      held_cnt++;
    end else begin
      dropped = 1'b1;
    end
    if (!rec.last_item) return;
    // Swap only when strictly smaller comes first, so ties keep arrival order
    for (int unsigned pass = 0; pass + 1 < held_cnt; pass++) begin
      for (int unsigned pos = 0; pos + 1 < held_cnt - pass; pos++) begin
        if (held_key[pos] < held_key[pos+1]) begin
          k = held_key[pos];
          t = held_tag[pos];
          held_key[pos] = held_key[pos+1];
          held_tag[pos] = held_tag[pos+1];
          held_key[pos+1] = k;
          held_tag[pos+1] = t;
        end
      end
    end
    for (int unsigned i = 0; i < held_cnt; i++) begin
      res.out_key = held_key[i];
      res.out_tag = held_tag[i];
      res.out_last = (i + 1 == held_cnt);
      res.overflowed = dropped;
      sorted_q.push_back(res);
    end
    held_cnt = 0;
    dropped = 1'b0;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  task automatic push_rec(logic [15:0] key, logic [15:0] tag, logic last);
    rbs_pkg::in_item_t rec;
    rec.key_count = key;
    rec.tag_id = tag;
    rec.last_item = last;
    feed_q.push_back(rec);
  endtask

  // Queue one batch of n records; the key style picks random, tie-heavy or extreme keys
  task automatic push_batch(int unsigned n, int unsigned key_style);
    logic [15:0] key;
    for (int unsigned i = 0; i < n; i++) begin
      case (key_style)
        0: begin
          key = 16'($urandom);
        end
        1: begin
          key = 16'($urandom_range(3));
        end
        default: begin
          key = $urandom_range(1) ? 16'hffff : 16'h0000;
        end
      endcase
      push_rec(key, 16'($urandom), i + 1 == n);
    end
  endtask

  // Driver: present the next record at the falling edge, hold it until taken
  always @(negedge clk_i) begin
    bit calm;
    calm = (fed_cnt >= 100) && (fed_cnt < 160);
    if (took_item) feed_q.delete(0);
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took_item) begin
      start <= 1'b1;
    end else if (feed_q.size() > 0 && (calm || $urandom_range(99) >= IdlePct)) begin
      start <= 1'b1;
      rec_in <= feed_q[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: predict on each accepted record, check each result strobe
  always @(posedge clk_i) begin
    rbs_pkg::out_item_t want;
    took_item <= rst_ni && start && !busy;
    if (rst_ni && start && !busy) begin
      absorb_record(rec_in);
      fed_cnt++;
    end
    if (rst_ni && out_valid_o) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_item_o);
        err_cnt++;
      end else begin
        want = sorted_q.pop_front();
        check_field("out_key", 32'(want.out_key), 32'(out_item_o.out_key));
        check_field("out_tag", 32'(want.out_tag), 32'(out_item_o.out_tag));
        check_field("out_last", 32'(want.out_last), 32'(out_item_o.out_last));
        check_field("overflowed", 32'(want.overflowed), 32'(out_item_o.overflowed));
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned roll;
    // Single-record batches at the key and tag extremes
    push_rec(16'hffff, 16'h0000, 1'b1);
    push_rec(16'h0000, 16'hffff, 1'b1);
    // Ties around a larger key keep their arrival order
    push_rec(16'd5, 16'h0001, 1'b0);
    push_rec(16'd5, 16'h0002, 1'b0);
    push_rec(16'd7, 16'h0003, 1'b0);
    push_rec(16'd5, 16'h0004, 1'b1);
    // Ascending keys get fully reversed
    push_rec(16'h0000, 16'haaaa, 1'b0);
    push_rec(16'h0001, 16'h5555, 1'b0);
    push_rec(16'h7fff, 16'h8000, 1'b0);
    push_rec(16'h8000, 16'h7fff, 1'b0);
    push_rec(16'hffff, 16'hffff, 1'b1);
    // All keys equal
    push_rec(16'hffff, 16'h0010, 1'b0);
    push_rec(16'hffff, 16'h0020, 1'b0);
    push_rec(16'hffff, 16'h0030, 1'b1);
    // Random batches, mostly short, some exactly full and some overflowing
    n = 0;
    while (n < RandItems) begin
      roll = $urandom_range(99);
      if (roll < 70) roll = $urandom_range(8, 1);
      else if (roll < 82) roll = $urandom_range(Depth - 1, 9);
      else if (roll < 90) roll = Depth;
      else roll = $urandom_range(Depth + 8, Depth + 1);
      push_batch(roll, $urandom_range(2));
      n += roll;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: all records taken, all sorted results seen, then let the block settle
    while (feed_q.size() != 0 || start) @(posedge clk_i);
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("record_bubble_sort_by_key test passed");
    end else begin
      $display("record_bubble_sort_by_key test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("record_bubble_sort_by_key test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rbs_pkg.sv
hdl/record_bubble_sort_by_key.sv
sim/tb_record_bubble_sort_by_key.sv
